>>> rtl/mcps_pkg.sv
// ----------------------------------------------------------------------------
// Multi-channel periodic scheduler package
// Word layouts, action codes, controller handshake types and table constants
// shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package mcps_pkg;

    localparam int CHANNELS_DEF = 32;

    // Action codes carried in the action field of an input word.
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_REG     = 3'd1;
    localparam logic [2:0] ACT_UNREG   = 3'd2;
    localparam logic [2:0] ACT_BURST   = 3'd3;
    localparam logic [2:0] ACT_RELAX   = 3'd4;

    // The phase wraps at this count, and the reported wait never exceeds it.
    localparam logic [3:0] PHASE_MOD   = 4'd10;
    localparam logic [3:0] WAIT_CAP    = 4'd10;

    // Reciprocal of ten scaled by 2^16, used to split the phase sum.
    localparam logic [12:0] RECIP_TEN  = 13'd6554;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  channel;
        logic [15:0] relax_units;
        logic [15:0] burst_units;
        logic        has_init;
        logic [9:0]  passed_units;
    } item_t;

    typedef struct packed {
        logic [4:0]  fired_channel;
        logic        fire_init;
        logic        fire_main;
        logic [3:0]  next_wait;
        logic        status;
        logic        last_result;
    } result_t;

    // One table entry: flags, both periods and both down counters.
    typedef struct packed {
        logic               sub;
        logic               burst;
        logic               align;
        logic               init;
        logic [15:0]        burst_per;
        logic [15:0]        relax_per;
        logic signed [16:0] cnt_burst;
        logic signed [16:0] cnt_relax;
    } row_t;

    typedef struct packed {
        logic load;
        logic edit_rd;
        logic edit_wr;
        logic tick_start;
        logic walk;
        logic reply;
        logic emit_final;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic bad_arg;
        logic walk_done;
    } stat_t;

endpackage

>>> rtl/multi_channel_periodic_scheduler_core.sv
// ----------------------------------------------------------------------------
// Multi-channel periodic scheduler core
// Table of timer channels with relax and burst periods, edited by command
// words and walked once per tick word to report firing channels.
//
//   Port          Dir  Width  Role
//   clk           in   1      clock
//   rst_n         in   1      asynchronous reset, active low
//   start         in   1      request, a word is taken when busy is low
//   item          in   51     command word
//   busy          out  1      high while a word is being worked on
//   result_valid  out  1      one-cycle strobe for each result word
//   result        out  13     result word
//
// An edit word keeps the core busy through a decode and an edit step, a
// rejected word through decode alone; the reply shows in the cycle busy
// falls. For a tick word the table, a memory with one read and one write
// port, is walked one channel per cycle after a decode step, with a read
// ahead of the first entry and a final word at the end. Reset clears the
// table's valid bits at once, so the core takes words right after reset.
// Result words cannot be held off.
// ----------------------------------------------------------------------------
module multi_channel_periodic_scheduler_core
#(
    parameter int CHANNELS = mcps_pkg::CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mcps_pkg::item_t   item,
    output logic              busy,
    output logic              result_valid,
    output mcps_pkg::result_t result
);

    mcps_pkg::cmd_t  cmd;
    mcps_pkg::stat_t stat;

    mcps_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    mcps_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

    // The final word of an item always appears as the core goes idle.
    a_last_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |-> !busy)
        else $error("final result word while still busy");

    // Channel fire words only come out during a walk.
    a_fire_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |-> busy)
        else $error("channel result word outside a walk");

    // Every channel word fires the main event.
    a_fire_has_main: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |-> result.fire_main)
        else $error("channel result word without main event");

    // Nothing is reported in the cycle right after a word is taken.
    a_quiet_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !result_valid)
        else $error("result word right after accepting a word");

endmodule

>>> rtl/mcps_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences decode, channel edits and the tick walk over the channel table.
// ----------------------------------------------------------------------------
module mcps_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mcps_pkg::stat_t stat,
    output logic            busy,
    output mcps_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EDIT,
        S_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_tick)
                begin
                    cmd.tick_start = 1'b1;
                    state_next     = S_WALK;
                end
                else if (stat.bad_arg)
                begin
                    cmd.reply  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.edit_rd = 1'b1;
                    state_next  = S_EDIT;
                end
            end
            S_EDIT:
            begin
                cmd.edit_wr = 1'b1;
                cmd.reply   = 1'b1;
                state_next  = S_IDLE;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

>>> rtl/mcps_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Channel table memory, phase counter, per-channel countdown logic, the
// running minimum wait and the result register.
// ----------------------------------------------------------------------------
module mcps_datapath
#(
    parameter int CHANNELS = mcps_pkg::CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mcps_pkg::item_t   item,
    input  mcps_pkg::cmd_t    cmd,
    output mcps_pkg::stat_t   stat,
    output logic              result_valid,
    output mcps_pkg::result_t result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [5:0]       CH_LIM  = 6'(CHANNELS);
    localparam logic [CNT_W-1:0] IDX_END = CNT_W'(CHANNELS);

    mcps_pkg::item_t   item_reg;
    mcps_pkg::row_t    row_mem [CHANNELS];
    mcps_pkg::row_t    row_q_reg;
    logic              row_vld_reg;
    logic [CHANNELS-1:0] vld_reg;

    logic [3:0]        phase_reg;
    logic [3:0]        phase_next;
    logic [3:0]        wait_reg;
    logic [3:0]        wait_next;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              proc_vld_reg;
    logic [IDX_W-1:0]  proc_idx_reg;

    mcps_pkg::result_t out_reg;
    mcps_pkg::result_t out_next;
    logic              out_vld_reg;
    logic              out_vld_next;

    logic [5:0]        ch_ext;
    logic [IDX_W-1:0]  ch_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    mcps_pkg::row_t    wr_data;
    mcps_pkg::row_t    row;
    mcps_pkg::row_t    edit_row;
    mcps_pkg::row_t    walk_row;

    logic [10:0]        ph_sum;
    logic [23:0]        ph_prod;
    logic [7:0]         ph_quo;
    logic [10:0]        ph_diff;
    logic signed [16:0] pass_s;
    logic signed [16:0] cb;
    logic signed [16:0] cr;
    logic               cb_exp;
    logic               cr_exp;
    logic signed [16:0] cb_new;
    logic signed [16:0] cr_new;
    logic signed [16:0] cand;
    logic [3:0]         req;
    logic               go;
    logic               fi;
    logic               fm;
    logic               walk_wr;
    logic               emit;

    assign ch_ext  = {1'b0, item_reg.channel};
    assign ch_addr = ch_ext[IDX_W-1:0];

    // Tick flag, argument checks for edit words and the walk-done flag.
    always_comb
    begin
        stat.is_tick = (item_reg.action == mcps_pkg::ACT_TICK);
        stat.bad_arg = !(item_reg.action inside {[mcps_pkg::ACT_TICK:mcps_pkg::ACT_RELAX]})
                       || (ch_ext >= CH_LIM)
                       || ((item_reg.action == mcps_pkg::ACT_REG)
                           && (item_reg.relax_units == '0))
                       || ((item_reg.action == mcps_pkg::ACT_BURST)
                           && (item_reg.burst_units == '0));
        stat.walk_done = (rd_idx_reg == IDX_END) && !proc_vld_reg;
    end

    // New phase is (phase + passed) mod 10, via a reciprocal multiply.
    always_comb
    begin
        ph_sum     = {7'd0, phase_reg} + {1'b0, item_reg.passed_units};
        ph_prod    = {13'd0, ph_sum} * {11'd0, mcps_pkg::RECIP_TEN};
        ph_quo     = ph_prod[23:16];
        ph_diff    = ph_sum - ({ph_quo, 3'b000} + {2'b00, ph_quo, 1'b0});
        phase_next = ph_diff[3:0];
    end

    // An entry never written since reset reads as all zero.
    assign row = row_vld_reg ? row_q_reg : '0;

    always_comb
    begin
        edit_row = row;
        case (item_reg.action)
            mcps_pkg::ACT_REG:
            begin
                edit_row           = '0;
                edit_row.sub       = 1'b1;
                edit_row.init      = item_reg.has_init;
                edit_row.relax_per = item_reg.relax_units;
                edit_row.burst_per = item_reg.burst_units;
            end
            mcps_pkg::ACT_UNREG:
            begin
                edit_row = '0;
            end
            mcps_pkg::ACT_BURST:
            begin
                edit_row.burst = 1'b1;
            end
            mcps_pkg::ACT_RELAX:
            begin
                edit_row.burst = 1'b0;
            end
            default:
            begin
                edit_row = row;
            end
        endcase
    end

    // Per-channel tick work on the entry read in the previous cycle.
    always_comb
    begin
        pass_s = signed'({7'd0, item_reg.passed_units});
        cb     = row.cnt_burst - pass_s;
        cr     = row.cnt_relax - pass_s;
        cb_exp = cb[16] || (cb == '0);
        cr_exp = cr[16] || (cr == '0);
        cb_new = cb_exp ? signed'({1'b0, row.burst_per}) : cb;
        cr_new = cr_exp ? signed'({1'b0, row.relax_per}) : cr;
        cand   = row.burst ? cb_new : cr_new;
        req    = mcps_pkg::PHASE_MOD - phase_reg;
        go     = row.align || (phase_reg == '0);
        fi     = !row.align && row.init;
        fm     = !row.align || (row.burst ? cb_exp : cr_exp);

        walk_row           = row;
        walk_row.align     = 1'b1;
        walk_row.cnt_burst = cb_new;
        walk_row.cnt_relax = cr_new;

        walk_wr   = cmd.walk && proc_vld_reg && row.sub && go;
        emit      = walk_wr && (fi || fm);

        wait_next = wait_reg;
        if (cmd.tick_start)
        begin
            wait_next = mcps_pkg::WAIT_CAP;
        end
        else if (cmd.walk && proc_vld_reg && row.sub)
        begin
            if (!go)
            begin
                if (req < wait_reg)
                begin
                    wait_next = req;
                end
            end
            else if ((cand[16:4] == '0) && (cand[3:0] < wait_reg))
            begin
                wait_next = cand[3:0];
            end
        end
    end

    always_comb
    begin
        rd_en   = cmd.edit_rd || (cmd.walk && (rd_idx_reg != IDX_END));
        rd_addr = cmd.walk ? rd_idx_reg[IDX_W-1:0] : ch_addr;
        wr_en   = cmd.edit_wr || walk_wr;
        wr_addr = cmd.edit_wr ? ch_addr : proc_idx_reg;
        wr_data = cmd.edit_wr ? edit_row : walk_row;
    end

    // Result word: a channel fire, the final tick word, or an edit reply.
    always_comb
    begin
        out_next     = out_reg;
        out_vld_next = 1'b0;
        if (emit)
        begin
            out_next               = '0;
            out_next.fired_channel = 5'(proc_idx_reg);
            out_next.fire_init     = fi;
            out_next.fire_main     = fm;
            out_vld_next           = 1'b1;
        end
        else if (cmd.emit_final)
        begin
            out_next             = '0;
            out_next.next_wait   = wait_reg;
            out_next.last_result = 1'b1;
            out_vld_next         = 1'b1;
        end
        else if (cmd.reply)
        begin
            out_next             = '0;
            out_next.status      = stat.bad_arg;
            out_next.last_result = 1'b1;
            out_vld_next         = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            row_q_reg <= row_mem[rd_addr];
        end
        if (cmd.load)
        begin
            item_reg <= item;
        end
        out_reg  <= out_next;
        wait_reg <= wait_next;
        if (cmd.walk && rd_en)
        begin
            proc_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            row_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
            rd_idx_reg   <= '0;
            proc_vld_reg <= 1'b0;
            phase_reg    <= '0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                row_vld_reg <= vld_reg[rd_addr];
            end
            if (cmd.tick_start)
            begin
                phase_reg <= phase_next;
            end
            if (cmd.tick_start)
            begin
                rd_idx_reg   <= '0;
                proc_vld_reg <= 1'b0;
            end
            else if (cmd.walk)
            begin
                proc_vld_reg <= rd_en;
                if (rd_en)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule
